// File: sv/rab_pkg.sv
package rab_pkg;

   localparam int unsigned NumAxes = 3;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   typedef logic signed [15:0] quat_type;
   typedef logic signed [31:0] coord_type;
   typedef logic        [23:0] scale_type;
   typedef logic signed [24:0] scale_delta_type;
   typedef logic signed [31:0] qprod_type;
   typedef logic signed [22:0] mat_type;
   typedef logic signed [54:0] term_type;
   typedef logic signed [57:0] acc_type;
   typedef logic signed [41:0] bound_type;
   typedef logic signed [47:0] part_type;
   typedef logic signed [52:0] widen_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   localparam coord_type BoxMinReset = -32'sd65536;
   localparam coord_type BoxMaxReset = 32'sd65536;

   typedef struct packed {
      quat_type  quat_w;
      quat_type  quat_x;
      quat_type  quat_y;
      quat_type  quat_z;
      coord_type [NumAxes-1:0] offset;
      scale_type scale_factor;
   } pose_type;

   typedef struct packed {
      qprod_type xx, yy, zz, xy, xz, yz, wx, wy, wz;
      coord_type [NumAxes-1:0] offset;
      scale_type scale_factor;
   } qprod_stage_type;

   typedef struct packed {
      mat_type   [NumAxes-1:0][NumAxes-1:0] m;
      coord_type [NumAxes-1:0] offset;
      scale_type scale_factor;
   } matrix_stage_type;

   typedef struct packed {
      acc_type   [NumAxes-1:0] lo;
      acc_type   [NumAxes-1:0] hi;
      scale_type scale_factor;
   } sum_stage_type;

   typedef struct packed {
      coord_type [NumAxes-1:0] lower;
      coord_type [NumAxes-1:0] upper;
      logic      overflow;
   } result_type;

endpackage

// File: sv/rab_if.sv
interface rab_req_if;
   import rab_pkg::*;
   logic      valid;
   logic      ready;
   quat_type  quat_w;
   quat_type  quat_x;
   quat_type  quat_y;
   quat_type  quat_z;
   coord_type offset_x;
   coord_type offset_y;
   coord_type offset_z;
   scale_type scale_factor;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, offset_x, offset_y,
                   offset_z, scale_factor, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, offset_x, offset_y,
                 offset_z, scale_factor, output ready);
endinterface

interface rab_rsp_if;
   import rab_pkg::*;
   logic      valid;
   logic      ready;
   coord_type lower_x;
   coord_type lower_y;
   coord_type lower_z;
   coord_type upper_x;
   coord_type upper_y;
   coord_type upper_z;
   logic      overflow;

   modport source (output valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
                   overflow, input ready);
   modport sink (input valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
                 overflow, output ready);
endinterface

// File: sv/rab_quat.sv
module rab_quat (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  rab_pkg::pose_type           in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rab_pkg::matrix_stage_type   out_data
);
   import rab_pkg::*;

   localparam logic signed [34:0] One = 35'sd1 <<< 28;
   localparam logic signed [34:0] Half = 35'sd2048;

   logic             s1_valid_ff, s2_valid_ff;
   logic             s1_ready, s2_ready;
   qprod_stage_type  s1_ff, s1_in;
   matrix_stage_type s2_ff, s2_in;
   logic signed [34:0] r [NumAxes][NumAxes];

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data = s2_ff;

   // quaternion cross products, exact in q.28
   always_comb begin
      s1_in.xx = in_data.quat_x * in_data.quat_x;
      s1_in.yy = in_data.quat_y * in_data.quat_y;
      s1_in.zz = in_data.quat_z * in_data.quat_z;
      s1_in.xy = in_data.quat_x * in_data.quat_y;
      s1_in.xz = in_data.quat_x * in_data.quat_z;
      s1_in.yz = in_data.quat_y * in_data.quat_z;
      s1_in.wx = in_data.quat_w * in_data.quat_x;
      s1_in.wy = in_data.quat_w * in_data.quat_y;
      s1_in.wz = in_data.quat_w * in_data.quat_z;
      s1_in.offset = in_data.offset;
      s1_in.scale_factor = in_data.scale_factor;
   end

   // rotation matrix, row i column j, rounded half up to q.16
   always_comb begin
      r[0][0] = One - ((35'(s1_ff.yy) + 35'(s1_ff.zz)) <<< 1);
      r[0][1] = (35'(s1_ff.xy) - 35'(s1_ff.wz)) <<< 1;
      r[0][2] = (35'(s1_ff.xz) + 35'(s1_ff.wy)) <<< 1;
      r[1][0] = (35'(s1_ff.xy) + 35'(s1_ff.wz)) <<< 1;
      r[1][1] = One - ((35'(s1_ff.xx) + 35'(s1_ff.zz)) <<< 1);
      r[1][2] = (35'(s1_ff.yz) - 35'(s1_ff.wx)) <<< 1;
      r[2][0] = (35'(s1_ff.xz) - 35'(s1_ff.wy)) <<< 1;
      r[2][1] = (35'(s1_ff.yz) + 35'(s1_ff.wx)) <<< 1;
      r[2][2] = One - ((35'(s1_ff.xx) + 35'(s1_ff.yy)) <<< 1);
      for (int i = 0; i < NumAxes; i++) begin
         for (int j = 0; j < NumAxes; j++) begin
            s2_in.m[i][j] = mat_type'((r[i][j] + Half) >>> 12);
         end
      end
      s2_in.offset = s1_ff.offset;
      s2_in.scale_factor = s1_ff.scale_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
   end

endmodule

// File: sv/rab_bounds.sv
module rab_bounds (
   input  logic                                       clock,
   input  logic                                       reset,
   input  rab_pkg::coord_type [rab_pkg::NumAxes-1:0]  box_min,
   input  rab_pkg::coord_type [rab_pkg::NumAxes-1:0]  box_max,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  rab_pkg::matrix_stage_type                  in_data,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output rab_pkg::sum_stage_type                     out_data
);
   import rab_pkg::*;

   typedef struct packed {
      term_type  [NumAxes-1:0][NumAxes-1:0] e;
      term_type  [NumAxes-1:0][NumAxes-1:0] f;
      coord_type [NumAxes-1:0] offset;
      scale_type scale_factor;
   } term_stage_type;

   logic           s3_valid_ff, s4_valid_ff;
   logic           s3_ready, s4_ready;
   term_stage_type s3_ff, s3_in;
   sum_stage_type  s4_ff, s4_in;
   acc_type        lo_acc, hi_acc;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;
   assign out_valid = s4_valid_ff;
   assign out_data = s4_ff;

   // one product per matrix entry and box corner
   always_comb begin
      for (int i = 0; i < NumAxes; i++) begin
         for (int j = 0; j < NumAxes; j++) begin
            s3_in.e[i][j] = term_type'(in_data.m[i][j] * box_min[j]);
            s3_in.f[i][j] = term_type'(in_data.m[i][j] * box_max[j]);
         end
      end
      s3_in.offset = in_data.offset;
      s3_in.scale_factor = in_data.scale_factor;
   end

   // smaller term to the lower bound, larger to the upper
   always_comb begin
      lo_acc = '0;
      hi_acc = '0;
      for (int i = 0; i < NumAxes; i++) begin
         lo_acc = acc_type'(s3_ff.offset[i]) <<< 16;
         hi_acc = lo_acc;
         for (int j = 0; j < NumAxes; j++) begin
            if (s3_ff.e[i][j] < s3_ff.f[i][j]) begin
               lo_acc = lo_acc + acc_type'(s3_ff.e[i][j]);
               hi_acc = hi_acc + acc_type'(s3_ff.f[i][j]);
            end else begin
               lo_acc = lo_acc + acc_type'(s3_ff.f[i][j]);
               hi_acc = hi_acc + acc_type'(s3_ff.e[i][j]);
            end
         end
         s4_in.lo[i] = lo_acc;
         s4_in.hi[i] = hi_acc;
      end
      s4_in.scale_factor = s3_ff.scale_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) s3_valid_ff <= in_valid;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) s3_ff <= s3_in;
      if (s4_ready && s3_valid_ff) s4_ff <= s4_in;
   end

endmodule

// File: sv/rab_scale.sv
module rab_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rab_pkg::sum_stage_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rab_pkg::result_type     out_data
);
   import rab_pkg::*;

   typedef logic signed [69:0] wprod_type;
   typedef logic signed [54:0] edge_type;

   typedef struct packed {
      bound_type [NumAxes-1:0] lo16;
      bound_type [NumAxes-1:0] hi16;
      part_type  [NumAxes-1:0] p_lo;
      part_type  [NumAxes-1:0] p_hi;
   } part_stage_type;

   typedef struct packed {
      bound_type [NumAxes-1:0] lo16;
      bound_type [NumAxes-1:0] hi16;
      widen_type [NumAxes-1:0] d;
   } widen_stage_type;

   localparam acc_type RoundAcc = 58'sd32768;
   localparam wprod_type RoundProd = 70'sd65536;
   localparam edge_type CoordMax = 55'sd2147483647;
   localparam edge_type CoordMin = -55'sd2147483648;

   logic            s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic            s5_ready, s6_ready, s7_ready;
   part_stage_type  s5_ff, s5_in;
   widen_stage_type s6_ff, s6_in;
   result_type      s7_ff, s7_in;
   scale_delta_type scl;
   bound_type       lo_r, hi_r;
   logic signed [42:0] extent;
   logic signed [22:0] ext_lo;
   logic signed [20:0] ext_hi;
   wprod_type       wprod;
   edge_type        lo_e, hi_e;

   assign s7_ready = !s7_valid_ff || out_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign in_ready = s5_ready;
   assign out_valid = s7_valid_ff;
   assign out_data = s7_ff;

   // round sums to q.16, split the extent into two partial products
   always_comb begin
      scl = scale_delta_type'({1'b0, in_data.scale_factor}) - 25'sd65536;
      lo_r = '0;
      hi_r = '0;
      extent = '0;
      ext_lo = '0;
      ext_hi = '0;
      for (int i = 0; i < NumAxes; i++) begin
         lo_r = bound_type'((in_data.lo[i] + RoundAcc) >>> 16);
         hi_r = bound_type'((in_data.hi[i] + RoundAcc) >>> 16);
         extent = 43'(hi_r) - 43'(lo_r);
         ext_lo = $signed({1'b0, extent[21:0]});
         ext_hi = extent[42:22];
         s5_in.lo16[i] = lo_r;
         s5_in.hi16[i] = hi_r;
         s5_in.p_lo[i] = part_type'(ext_lo * scl);
         s5_in.p_hi[i] = part_type'(ext_hi * scl);
      end
   end

   // recombine, halve and round the widening amount
   always_comb begin
      wprod = '0;
      for (int i = 0; i < NumAxes; i++) begin
         wprod = (wprod_type'(s5_ff.p_hi[i]) <<< 22) + wprod_type'(s5_ff.p_lo[i]);
         s6_in.d[i] = widen_type'((wprod + RoundProd) >>> 17);
      end
      s6_in.lo16 = s5_ff.lo16;
      s6_in.hi16 = s5_ff.hi16;
   end

   // move bounds apart by the widening amount (together when it is negative) and saturate
   always_comb begin
      lo_e = '0;
      hi_e = '0;
      s7_in.overflow = 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
         lo_e = edge_type'(s6_ff.lo16[i]) - edge_type'(s6_ff.d[i]);
         hi_e = edge_type'(s6_ff.hi16[i]) + edge_type'(s6_ff.d[i]);
         priority if (lo_e > CoordMax) begin
            s7_in.lower[i] = coord_type'(CoordMax);
            s7_in.overflow = 1'b1;
         end else if (lo_e < CoordMin) begin
            s7_in.lower[i] = coord_type'(CoordMin);
            s7_in.overflow = 1'b1;
         end else begin
            s7_in.lower[i] = coord_type'(lo_e);
         end
         priority if (hi_e > CoordMax) begin
            s7_in.upper[i] = coord_type'(CoordMax);
            s7_in.overflow = 1'b1;
         end else if (hi_e < CoordMin) begin
            s7_in.upper[i] = coord_type'(CoordMin);
            s7_in.overflow = 1'b1;
         end else begin
            s7_in.upper[i] = coord_type'(hi_e);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s5_ready) s5_valid_ff <= in_valid;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready && in_valid) s5_ff <= s5_in;
      if (s6_ready && s5_valid_ff) s6_ff <= s6_in;
      if (s7_ready && s6_valid_ff) s7_ff <= s7_in;
   end

endmodule

// File: sv/rotated_aabb_bounds_top.sv
// rotated box bounds: rotates a configured box by a quaternion, translates it and
// scales it about its center, giving the new axis-aligned lower and upper bounds
// req channel: one pose per transaction (q2.14 quaternion, q16.16 offset, q8.16 scale)
// rsp channel: one transaction per pose with six q16.16 bounds and a saturation flag
// csr port: write enable, index and data set the box corners (indexes 0..5); the user
//   must write them only while no transaction is in flight, which the block does not
//   enforce; other indexes are ignored
// pipeline: one register stage each for quaternion products, matrix, corner products,
//   sums, rounding and split scale multiply, widening recombine, and saturation into
//   the output register
// throughput: one transaction per cycle while rsp ready is high, set by the seven-stage pipeline
// reset: synchronous, clears all stage valid bits and loads the unit box [-1, +1]
// stall: when rsp ready is low each stage holds its data; empty stages still fill,
//   so req is taken until every stage is occupied, then req ready drops
module rotated_aabb_bounds_top (
   input  logic                                 clock,
   input  logic                                 reset,
   rab_req_if.sink                              req,
   rab_rsp_if.source                            rsp,
   input  logic                                 csr_write_enable,
   input  logic [rab_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rab_pkg::CsrDataWidth-1:0]     csr_write_data
);
   import rab_pkg::*;

   coord_type [NumAxes-1:0] box_min_ff;
   coord_type [NumAxes-1:0] box_max_ff;

   pose_type         pose;
   matrix_stage_type matrix_data;
   sum_stage_type    sum_data;
   result_type       result;
   logic             matrix_valid, matrix_ready;
   logic             sum_valid, sum_ready;

   // box corner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= {NumAxes{BoxMinReset}};
         box_max_ff <= {NumAxes{BoxMaxReset}};
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_write_data;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_write_data;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_write_data;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_write_data;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_write_data;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // gather request fields
   always_comb begin
      pose.quat_w = req.quat_w;
      pose.quat_x = req.quat_x;
      pose.quat_y = req.quat_y;
      pose.quat_z = req.quat_z;
      pose.offset[0] = req.offset_x;
      pose.offset[1] = req.offset_y;
      pose.offset[2] = req.offset_z;
      pose.scale_factor = req.scale_factor;
   end

   // stages 1-2: quaternion to rotation matrix
   rab_quat u_quat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (pose),
      .out_valid (matrix_valid),
      .out_ready (matrix_ready),
      .out_data  (matrix_data)
   );

   // stages 3-4: corner products and min/max sums per axis
   rab_bounds u_bounds (
      .clock     (clock),
      .reset     (reset),
      .box_min   (box_min_ff),
      .box_max   (box_max_ff),
      .in_valid  (matrix_valid),
      .in_ready  (matrix_ready),
      .in_data   (matrix_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   // stages 5-7: rounding, scale widening, saturation, output register
   rab_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (result)
   );

   assign rsp.lower_x = result.lower[0];
   assign rsp.lower_y = result.lower[1];
   assign rsp.lower_z = result.lower[2];
   assign rsp.upper_x = result.upper[0];
   assign rsp.upper_y = result.upper[1];
   assign rsp.upper_z = result.upper[2];
   assign rsp.overflow = result.overflow;

endmodule
